// ----- sv/tocr_pkg.sv -----
// Package for the text overlay cell renderer: payload types, codes and command/status structs.
package tocr_pkg;

    // Default geometry
    localparam int unsigned CELL_COLUMNS_DEFAULT = 85;
    localparam int unsigned PIXEL_ROWS_DEFAULT   = 768;

    // Store geometry
    localparam int unsigned CELL_ADDR_W = 14;
    localparam int unsigned CELL_DEPTH  = 16384;
    localparam int unsigned FONT_ADDR_W = 11;
    localparam int unsigned FONT_DEPTH  = 2048;

    // Configuration port
    localparam int unsigned CFG_INDEX_W = 2;

    // Colour used for a cursor cell
    localparam logic [2:0] CURSOR_COLOUR = 3'h7;

    typedef enum logic [1:0] {
        CMD_WRITE_CELL = 2'd0,
        CMD_WRITE_FONT = 2'd1,
        CMD_BLINK_TICK = 2'd2,
        CMD_RENDER     = 2'd3
    } command_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CURSOR_BLINK = 2'd0,
        CFG_CHAR_BLINK   = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [13:0] mem_address;
        logic [15:0] write_data;
        logic [9:0]  pixel_row;
        logic [6:0]  cell_column;
    } in_item_t;

    typedef struct packed {
        logic [23:0] pixel_colors;
        logic [7:0]  pixel_written;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_HI,
        ST_READ_LO,
        ST_READ_FONT,
        ST_DRAW
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic write_cell;
        logic write_font;
        logic phase_toggle;
        logic read_hi;
        logic read_lo;
        logic read_font;
        logic load_out;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

// ----- sv/tocr_ctrl.sv -----
// Controller state machine for the text overlay cell renderer.
module tocr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          in_command,
    input  tocr_pkg::dp_status_t status,
    output logic                in_stall,
    output tocr_pkg::dp_cmd_t   cmd
);

    tocr_pkg::state_t state_reg;
    tocr_pkg::state_t state_next;
    logic             accept;

    assign in_stall = (state_reg != tocr_pkg::ST_IDLE);
    assign accept   = in_valid && !in_stall;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tocr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tocr_pkg::ST_IDLE:
            begin
                if (accept && in_command == tocr_pkg::CMD_RENDER)
                begin
                    state_next = tocr_pkg::ST_READ_HI;
                end
            end
            tocr_pkg::ST_READ_HI:   state_next = tocr_pkg::ST_READ_LO;
            tocr_pkg::ST_READ_LO:   state_next = tocr_pkg::ST_READ_FONT;
            tocr_pkg::ST_READ_FONT: state_next = tocr_pkg::ST_DRAW;
            tocr_pkg::ST_DRAW:
            begin
                if (status.out_free)
                begin
                    state_next = tocr_pkg::ST_IDLE;
                end
            end
            default:                state_next = tocr_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            tocr_pkg::ST_IDLE:
            begin
                cmd.capture      = accept && in_command == tocr_pkg::CMD_RENDER;
                cmd.write_cell   = accept && in_command == tocr_pkg::CMD_WRITE_CELL;
                cmd.write_font   = accept && in_command == tocr_pkg::CMD_WRITE_FONT;
                cmd.phase_toggle = accept && in_command == tocr_pkg::CMD_BLINK_TICK;
            end
            tocr_pkg::ST_READ_HI:   cmd.read_hi   = 1'b1;
            tocr_pkg::ST_READ_LO:   cmd.read_lo   = 1'b1;
            tocr_pkg::ST_READ_FONT: cmd.read_font = 1'b1;
            tocr_pkg::ST_DRAW:      cmd.load_out  = status.out_free;
            default:                cmd = '0;
        endcase
    end

endmodule

// ----- sv/tocr_datapath.sv -----
// Datapath: cell and font memories, blink and config registers, pixel logic, output register.
module tocr_datapath #(
    parameter int unsigned CELL_COLUMNS = tocr_pkg::CELL_COLUMNS_DEFAULT,
    parameter int unsigned PIXEL_ROWS   = tocr_pkg::PIXEL_ROWS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tocr_pkg::dp_cmd_t                cmd,
    input  tocr_pkg::in_item_t               in_data,
    input  logic                             cfg_valid,
    input  logic [tocr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic                             cfg_data,
    input  logic                             out_stall,
    output logic                             out_valid,
    output tocr_pkg::out_item_t              out_data,
    output tocr_pkg::dp_status_t             status
);

    localparam int unsigned ROW_STRIDE = 2 * CELL_COLUMNS;

    logic [15:0] cell_mem [tocr_pkg::CELL_DEPTH];
    logic [7:0]  font_mem [tocr_pkg::FONT_DEPTH];

    logic        blink_phase_reg;
    logic        cursor_blink_reg;
    logic        char_blink_reg;
    logic        out_valid_reg;
    logic        out_valid_next;

    logic [tocr_pkg::CELL_ADDR_W-1:0] base_reg;
    logic [2:0]                       row_low_reg;
    logic                             in_range_reg;
    logic [15:0]                      cell_rd_reg;
    logic [15:0]                      hi_reg;
    logic [2:0]                       fg_reg;
    logic [7:0]                       glyph_reg;
    tocr_pkg::out_item_t              out_reg;

    logic [16:0]                      base_full;
    logic                             in_range;
    logic [tocr_pkg::CELL_ADDR_W-1:0] cell_rd_addr;
    logic [tocr_pkg::FONT_ADDR_W-1:0] font_rd_addr;
    tocr_pkg::out_item_t              pixels;
    logic                             lit_ok;

    // Cell base address and range check of a render request
    assign base_full = 17'(in_data.pixel_row[9:3]) * 17'(ROW_STRIDE)
                     + 17'({in_data.cell_column, 1'b0});
    assign in_range  = (11'(in_data.pixel_row) < 11'(PIXEL_ROWS))
                    && (8'(in_data.cell_column) < 8'(CELL_COLUMNS));

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            base_reg     <= base_full[tocr_pkg::CELL_ADDR_W-1:0];
            row_low_reg  <= in_data.pixel_row[2:0];
            in_range_reg <= in_range;
        end
    end

    // Cell memory: one write port, one registered read port
    assign cell_rd_addr = cmd.read_lo ? base_reg + 1'b1 : base_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.write_cell)
        begin
            cell_mem[in_data.mem_address] <= in_data.write_data;
        end
        if (cmd.read_hi || cmd.read_lo)
        begin
            cell_rd_reg <= cell_mem[cell_rd_addr];
        end
    end

    // Hold the attribute word while the second word is fetched, then the foreground colour of the second word
    always_ff @(posedge clk)
    begin
        if (cmd.read_lo)
        begin
            hi_reg <= cell_rd_reg;
        end
        if (cmd.read_font)
        begin
            fg_reg <= cell_rd_reg[10:8];
        end
    end

    // Font memory: writes beyond its depth are dropped
    assign font_rd_addr = {cell_rd_reg[7:0], row_low_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.write_font && in_data.mem_address[13:11] == 3'b000)
        begin
            font_mem[in_data.mem_address[10:0]] <= in_data.write_data[7:0];
        end
        if (cmd.read_font)
        begin
            glyph_reg <= font_mem[font_rd_addr];
        end
    end

    // Blink phase and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_phase_reg  <= 1'b0;
            cursor_blink_reg <= 1'b0;
            char_blink_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.phase_toggle)
            begin
                blink_phase_reg <= !blink_phase_reg;
            end
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    tocr_pkg::CFG_CURSOR_BLINK: cursor_blink_reg <= cfg_data;
                    tocr_pkg::CFG_CHAR_BLINK:   char_blink_reg   <= cfg_data;
                    default:                    ;
                endcase
            end
        end
    end

    // Pixel rule for the eight pixels of one font row
    assign lit_ok = !char_blink_reg || blink_phase_reg;

    always_comb
    begin
        pixels = '0;
        if (in_range_reg)
        begin
            if (hi_reg[15])
            begin
                if (!cursor_blink_reg || blink_phase_reg)
                begin
                    pixels.pixel_colors  = {8{tocr_pkg::CURSOR_COLOUR}};
                    pixels.pixel_written = 8'hff;
                end
            end
            else
            begin
                for (int x = 0; x < 8; x++)
                begin
                    if (glyph_reg[x] && lit_ok)
                    begin
                        if (hi_reg[12])
                        begin
                            pixels.pixel_colors[3*x +: 3] = fg_reg;
                            pixels.pixel_written[x]       = 1'b1;
                        end
                    end
                    else if (hi_reg[11])
                    begin
                        pixels.pixel_colors[3*x +: 3] = hi_reg[2:0];
                        pixels.pixel_written[x]       = 1'b1;
                    end
                end
            end
        end
    end

    // Output register
    assign status.out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg <= pixels;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ----- sv/text_overlay_cell_renderer.sv -----
// Top level of the text overlay cell renderer.
//
// Input channel (in_valid / in_stall / in_data) carries commands: write a
// cell word, write a font byte, toggle the blink phase, or render one font
// row of one cell. A transfer happens when in_valid is high and in_stall low.
// Writes and blink ticks leave the input free and produce no result.
// A render keeps the input stalled while it runs: the two cell words and
// the font row are fetched one after another through the single registered
// read port of each memory, so no new command is taken until it is done.
// Its result is loaded into the output register in the draw step (ST_DRAW)
// and waits there, under out_stall, until taken; the next command may be
// taken meanwhile, and a following render waits in its last step only while
// the output register is still full.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) sets the
// cursor and character blink enables; cfg_ready is always high.
// Reset clears the blink phase, both enables and the output valid flag; the
// cell and font memories hold nothing defined until written.
module text_overlay_cell_renderer #(
    parameter int unsigned CELL_COLUMNS = tocr_pkg::CELL_COLUMNS_DEFAULT,
    parameter int unsigned PIXEL_ROWS   = tocr_pkg::PIXEL_ROWS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  tocr_pkg::in_item_t               in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output tocr_pkg::out_item_t              out_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tocr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic                             cfg_data
);

    tocr_pkg::dp_cmd_t    cmd;
    tocr_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    tocr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_command (in_data.command),
        .status     (status),
        .in_stall   (in_stall),
        .cmd        (cmd)
    );

    tocr_datapath #(
        .CELL_COLUMNS (CELL_COLUMNS),
        .PIXEL_ROWS   (PIXEL_ROWS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .status    (status)
    );

endmodule

// ----- sv/tocr_checker.sv -----
// Port-level checker for the text overlay cell renderer, bound to the top level.
module tocr_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input tocr_pkg::in_item_t  in_data,
    input logic                out_valid,
    input logic                out_stall,
    input tocr_pkg::out_item_t out_data
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed or dropped");

    // A render keeps the input busy while it fetches
    a_render_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.command == tocr_pkg::CMD_RENDER
        |=> in_stall)
        else $error("input not stalled after render transfer");

    // Writes and ticks leave the input free and raise no result
    a_write_quick: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.command != tocr_pkg::CMD_RENDER && !out_valid
        |=> !in_stall && !out_valid)
        else $error("non-render command stalled input or raised a result");

    // A fully transparent row carries no colour
    a_clear_colours: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.pixel_written == 8'h00 |-> out_data.pixel_colors == 24'h0)
        else $error("colour present on undrawn pixels");

endmodule

bind text_overlay_cell_renderer tocr_checker u_tocr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
